### rtl/imn_pkg.sv
// imn_pkg: shared types and fixed constants of the interleaved min-max normalizer.
// No dependencies; used by imn_divider, imn_window and interleaved_minmax_normalizer.
`default_nettype none

package imn_pkg;

	localparam int unsigned SAMPLE_PORT_BITS = 16;
	localparam int unsigned NORM_BITS        = 16;
	localparam int unsigned STEP_BITS        = 4;

	typedef struct packed {
		logic wr;
		logic rd;
		logic clear;
	} win_ctl_t;

	typedef enum logic [4:0] {
		S_LOAD  = 5'b00001,
		S_READ  = 5'b00010,
		S_SETUP = 5'b00100,
		S_DIV   = 5'b01000,
		S_EMIT  = 5'b10000
	} seq_state_t;

endpackage

`default_nettype wire

### rtl/imn_divider.sv
// imn_divider: restoring divider, one quotient bit per cycle, gives (a * 2^15) / d for a <= d.
// Depends on imn_pkg for the quotient width and step counter width.
`default_nettype none

module imn_divider #(
	parameter int unsigned WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [WIDTH-1:0]               dividend,
	input  wire logic [WIDTH-1:0]               divisor,
	output logic                                done,
	output logic [imn_pkg::NORM_BITS-1:0]       quotient
);

	logic [WIDTH:0]                      rem_q;
	logic [WIDTH-1:0]                    div_q;
	logic [imn_pkg::NORM_BITS-1:0]       quo_q;
	logic [imn_pkg::STEP_BITS-1:0]       step_q;
	logic                                busy_q;
	logic                                done_q;
	logic [WIDTH:0]                      sub_w;
	logic [WIDTH:0]                      sel_w;
	logic                                take_w;

	assign sub_w  = rem_q - {1'b0, div_q};
	assign take_w = rem_q >= {1'b0, div_q};
	assign sel_w  = take_w ? sub_w : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '1;
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - imn_pkg::STEP_BITS'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= {sel_w[WIDTH-1:0], 1'b0};
			quo_q <= {quo_q[imn_pkg::NORM_BITS-2:0], take_w};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### rtl/imn_window.sv
// imn_window: sample store with fill count, per-channel min/max tracking and overflow flag.
// Depends on imn_pkg for the control struct.
`default_nettype none

module imn_window #(
	parameter int unsigned WINDOW_DEPTH = 64,
	parameter int unsigned SAMPLE_BITS  = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire imn_pkg::win_ctl_t                     ctl,
	input  wire logic [SAMPLE_BITS-1:0]                wr_data,
	input  wire logic [$clog2(WINDOW_DEPTH)-1:0]       rd_addr,
	input  wire logic                                  sel_b,
	output logic [SAMPLE_BITS-1:0]                     rd_data,
	output logic [SAMPLE_BITS-1:0]                     ch_min,
	output logic [SAMPLE_BITS-1:0]                     ch_max,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0]          fill,
	output logic                                       overflow
);

	localparam int unsigned ADDR_BITS = $clog2(WINDOW_DEPTH);
	localparam int unsigned FILL_BITS = $clog2(WINDOW_DEPTH + 1);

	logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic [SAMPLE_BITS-1:0] min_a_q;
	logic [SAMPLE_BITS-1:0] max_a_q;
	logic [SAMPLE_BITS-1:0] min_b_q;
	logic [SAMPLE_BITS-1:0] max_b_q;
	logic [FILL_BITS-1:0]   fill_q;
	logic                   ovf_q;
	logic                   full_w;

	assign full_w = fill_q == FILL_BITS'(WINDOW_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			min_a_q <= '1;
			max_a_q <= '0;
			min_b_q <= '1;
			max_b_q <= '0;
		end else if (ctl.clear) begin
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			min_a_q <= '1;
			max_a_q <= '0;
			min_b_q <= '1;
			max_b_q <= '0;
		end else if (ctl.wr) begin
			if (full_w) begin
				ovf_q <= 1'b1;
			end else begin
				fill_q <= fill_q + FILL_BITS'(1);
				if (fill_q[0]) begin
					if (wr_data > max_b_q) max_b_q <= wr_data;
					if (wr_data < min_b_q) min_b_q <= wr_data;
				end else begin
					if (wr_data > max_a_q) max_a_q <= wr_data;
					if (wr_data < min_a_q) min_a_q <= wr_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr && !full_w) begin
			mem[fill_q[ADDR_BITS-1:0]] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign ch_min   = sel_b ? min_b_q : min_a_q;
	assign ch_max   = sel_b ? max_b_q : max_a_q;
	assign fill     = fill_q;
	assign overflow = ovf_q;

endmodule

`default_nettype wire

### rtl/interleaved_minmax_normalizer.sv
// Interleaved min-max normalizer, top level: sequencer, output register, store and divider.
// Depends on imn_pkg, imn_window and imn_divider.
//
// Samples load at one word per cycle unless stalled; even window positions are channel A, odd
// ones channel B. The word flagged last starts output: each stored sample leaves as
// (sample - channel min) * 32768 / (channel max - channel min), truncated, Q1.15.
// Each result passes a store read, a setup step, 16 steps of the shared one-bit-per-cycle
// divider, a look at the divider done and an output load; the load waits while the output
// is stalled.
// sample_stall is high from the last word until the final result of the window sits in the
// output register; a new window may load while that result still waits to be taken.
// Words beyond WINDOW_DEPTH are dropped and flagged on every result of the window.
`default_nettype none

module interleaved_minmax_normalizer #(
	parameter int unsigned WINDOW_DEPTH = 64,
	parameter int unsigned SAMPLE_BITS  = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   sample_valid,
	output logic                                        sample_stall,
	input  wire logic [imn_pkg::SAMPLE_PORT_BITS-1:0]   sample,
	input  wire logic                                   last,
	output logic                                        result_valid,
	input  wire logic                                   result_stall,
	output logic [imn_pkg::NORM_BITS-1:0]               normalized,
	output logic                                        channel,
	output logic                                        flat_range,
	output logic                                        overflowed,
	output logic                                        end_of_window
);

	localparam int unsigned ADDR_BITS = $clog2(WINDOW_DEPTH);
	localparam int unsigned FILL_BITS = $clog2(WINDOW_DEPTH + 1);

	imn_pkg::seq_state_t                 state_q;
	imn_pkg::win_ctl_t                   ctl_w;
	logic [ADDR_BITS-1:0]                idx_q;
	logic                                flat_q;
	logic                                accept_w;
	logic                                load_w;
	logic                                final_w;
	logic [SAMPLE_BITS-1:0]              rd_data_w;
	logic [SAMPLE_BITS-1:0]              ch_min_w;
	logic [SAMPLE_BITS-1:0]              ch_max_w;
	logic [FILL_BITS-1:0]                fill_w;
	logic                                ovf_w;
	logic                                div_done_w;
	logic [imn_pkg::NORM_BITS-1:0]       quo_w;
	logic                                res_valid_q;
	logic [imn_pkg::NORM_BITS-1:0]       norm_q;
	logic                                chan_q;
	logic                                flat_out_q;
	logic                                ovf_out_q;
	logic                                eow_q;

	assign sample_stall = state_q != imn_pkg::S_LOAD;
	assign accept_w     = sample_valid && !sample_stall;
	assign load_w       = (state_q == imn_pkg::S_EMIT) && (!res_valid_q || !result_stall);
	assign final_w      = (FILL_BITS'(idx_q) + FILL_BITS'(1)) == fill_w;

	assign ctl_w.wr    = accept_w;
	assign ctl_w.rd    = state_q == imn_pkg::S_READ;
	assign ctl_w.clear = load_w && final_w;

	imn_window #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_w),
		.wr_data  (SAMPLE_BITS'(sample)),
		.rd_addr  (idx_q),
		.sel_b    (idx_q[0]),
		.rd_data  (rd_data_w),
		.ch_min   (ch_min_w),
		.ch_max   (ch_max_w),
		.fill     (fill_w),
		.overflow (ovf_w)
	);

	imn_divider #(
		.WIDTH (SAMPLE_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == imn_pkg::S_SETUP),
		.dividend (rd_data_w - ch_min_w),
		.divisor  (ch_max_w - ch_min_w),
		.done     (div_done_w),
		.quotient (quo_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= imn_pkg::S_LOAD;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				imn_pkg::S_LOAD: begin
					if (accept_w && last) begin
						idx_q   <= '0;
						state_q <= imn_pkg::S_READ;
					end
				end
				imn_pkg::S_READ: begin
					state_q <= imn_pkg::S_SETUP;
				end
				imn_pkg::S_SETUP: begin
					state_q <= imn_pkg::S_DIV;
				end
				imn_pkg::S_DIV: begin
					if (div_done_w) state_q <= imn_pkg::S_EMIT;
				end
				imn_pkg::S_EMIT: begin
					if (load_w) begin
						res_valid_q <= 1'b1;
						if (final_w) begin
							state_q <= imn_pkg::S_LOAD;
						end else begin
							idx_q   <= idx_q + ADDR_BITS'(1);
							state_q <= imn_pkg::S_READ;
						end
					end
				end
				default: begin
					state_q <= imn_pkg::S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == imn_pkg::S_SETUP) begin
			flat_q <= ch_max_w <= ch_min_w;
		end
		if (load_w) begin
			norm_q     <= flat_q ? '0 : quo_w;
			chan_q     <= idx_q[0];
			flat_out_q <= flat_q;
			ovf_out_q  <= ovf_w;
			eow_q      <= final_w;
		end
	end

	assign result_valid  = res_valid_q;
	assign normalized    = norm_q;
	assign channel       = chan_q;
	assign flat_range    = flat_out_q;
	assign overflowed    = ovf_out_q;
	assign end_of_window = eow_q;

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for interleaved_minmax_normalizer: random windows with directed edges.
// A scoreboard class tracks per-channel min/max and predicts every normalized word.
// Depends on imn_pkg and the RTL top level only.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 64;
	localparam longint unsigned Q15_ONE = 32768;
	localparam int unsigned RANDOM_WORDS = 500;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned HOLD_OFF_LEN = 400;

	typedef enum int unsigned {
		FILL_RANDOM,
		FILL_NARROW,
		FILL_FLAT,
		FILL_EXTREME
	} fill_kind_t;

	typedef struct {
		logic [15:0] normalized;
		logic        channel;
		logic        flat_range;
		logic        overflowed;
		logic        end_of_window;
	} window_result_t;

	class normalizer_scoreboard;
		logic [15:0]    store [DEPTH];
		int unsigned    fill;
		logic [15:0]    lo_a, hi_a, lo_b, hi_b;
		logic           dropped;
		window_result_t expected_norms [$];
		int unsigned    errors;

		function new();
			errors = 0;
			clear_window();
		endfunction

		function void clear_window();
			fill = 0;
			lo_a = 16'hFFFF;
			hi_a = 16'h0000;
			lo_b = 16'hFFFF;
			hi_b = 16'h0000;
			dropped = 1'b0;
		endfunction

		function int unsigned pending();
			return expected_norms.size();
		endfunction

		function void note_word(logic [15:0] s, logic lst);
			window_result_t  r;
			logic [15:0]     lo, hi;
			longint unsigned num, den, q;
			if (fill < DEPTH) begin
				if (fill % 2 == 1) begin
					if (s > hi_b) hi_b = s;
					if (s < lo_b) lo_b = s;
				end else begin
					if (s > hi_a) hi_a = s;
					if (s < lo_a) lo_a = s;
				end
				store[fill] = s;
				fill++;
			end else begin
				dropped = 1'b1;
			end
			if (!lst) return;
			for (int unsigned i = 0; i < fill; i++) begin
				r.channel = (i % 2 == 1);
				lo = r.channel ? lo_b : lo_a;
				hi = r.channel ? hi_b : hi_a;
				r.flat_range = (hi <= lo);
				q = 0;
				if (!r.flat_range) begin
					num = store[i];
					num = (num - lo) * Q15_ONE;
					den = hi;
					den = den - lo;
					q = num / den;
					if (q > Q15_ONE) q = Q15_ONE;
				end
				r.normalized = q[15:0];
				r.overflowed = dropped;
				r.end_of_window = (i + 1 == fill);
				expected_norms.insert(expected_norms.size(), r);
			end
			clear_window();
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [15:0] n, logic ch, logic fl, logic ov, logic eow);
			window_result_t want;
			if (expected_norms.size() == 0) begin
				$display("%0t: unexpected word, normalized expected none actual %0d", $time, n);
				errors++;
				return;
			end
			want = expected_norms.pop_front();
			compare_field("normalized", want.normalized, n);
			compare_field("channel", 16'(want.channel), 16'(ch));
			compare_field("flat_range", 16'(want.flat_range), 16'(fl));
			compare_field("overflowed", 16'(want.overflowed), 16'(ov));
			compare_field("end_of_window", 16'(want.end_of_window), 16'(eow));
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              sample_valid;
	logic                              sample_stall;
	logic [imn_pkg::SAMPLE_PORT_BITS-1:0] sample;
	logic                              last;
	logic                              result_valid;
	logic                              result_stall;
	logic [imn_pkg::NORM_BITS-1:0]     normalized;
	logic                              channel;
	logic                              flat_range;
	logic                              overflowed;
	logic                              end_of_window;

	normalizer_scoreboard book = new();
	int unsigned send_idle_pct = 35;
	int unsigned recv_idle_pct = 80;
	int unsigned hold_off_cycles = 0;

	interleaved_minmax_normalizer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.normalized   (normalized),
		.channel      (channel),
		.flat_range   (flat_range),
		.overflowed   (overflowed),
		.end_of_window(end_of_window)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("interleaved_minmax_normalizer test failed");
		$finish;
	end

	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall)
				book.check_result(normalized, channel, flat_range, overflowed, end_of_window);
			if (hold_off_cycles > 0) begin
				result_stall <= 1'b1;
				hold_off_cycles--;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	task automatic send_word(input logic [15:0] v, input logic lst);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= v;
		last <= lst;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		book.note_word(v, lst);
	endtask

	task automatic send_queue(input logic [15:0] vals [$]);
		foreach (vals[i])
			send_word(vals[i], i == vals.size() - 1);
	endtask

	task automatic send_window(input int unsigned len, input fill_kind_t kind);
		logic [15:0] base;
		logic [15:0] v;
		int unsigned span;
		base = 16'($urandom_range(0, 65535));
		span = $urandom_range(1, 15);
		if (kind == FILL_NARROW && base > 65535 - span)
			base = 16'(65535 - span);
		for (int unsigned i = 0; i < len; i++) begin
			case (kind)
				FILL_RANDOM: v = 16'($urandom_range(0, 65535));
				FILL_NARROW: v = base + 16'($urandom_range(0, span));
				FILL_FLAT:   v = base;
				default:     v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			endcase
			send_word(v, i == len - 1);
		end
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0) @(posedge clk);
	endtask

	initial begin
		logic [15:0]  words [$];
		int unsigned  sent;
		int unsigned  win;
		int unsigned  len;
		int unsigned  pick;
		int unsigned  phase;
		fill_kind_t   kind;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		last <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		words = '{16'h0000};
		send_queue(words);
		words = '{16'hFFFF};
		send_queue(words);
		words = '{16'h0000, 16'hFFFF};
		send_queue(words);
		words = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
		send_queue(words);
		words = '{16'd1, 16'd2, 16'd65534, 16'd65535, 16'd32768, 16'd32767};
		send_queue(words);
		words = '{16'd7, 16'd7, 16'd7, 16'd7, 16'd7};
		send_queue(words);
		words = '{16'd100, 16'd5, 16'd101};
		send_queue(words);

		sent = 0;
		win = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			if (phase == 0 && sent >= RANDOM_WORDS / 3) begin
				wait_drained();
				send_idle_pct = 80;
				recv_idle_pct = 35;
				phase = 1;
			end else if (phase == 1 && sent >= 2 * RANDOM_WORDS / 3) begin
				wait_drained();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_off_cycles = HOLD_OFF_LEN;
				phase = 2;
			end
			// overflow windows end on a dropped word; some windows fill exactly
			if (win % 10 == 3)
				len = $urandom_range(DEPTH + 1, DEPTH + 4);
			else if (win % 10 == 8)
				len = DEPTH;
			else
				len = $urandom_range(1, 24);
			pick = $urandom_range(0, 9);
			if (pick < 5)
				kind = FILL_RANDOM;
			else if (pick < 7)
				kind = FILL_NARROW;
			else if (pick < 8)
				kind = FILL_FLAT;
			else
				kind = FILL_EXTREME;
			send_window(len, kind);
			sent += len;
			win++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.errors == 0)
			$display("interleaved_minmax_normalizer test passed");
		else
			$display("interleaved_minmax_normalizer test failed");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/imn_pkg.sv
rtl/imn_divider.sv
rtl/imn_window.sv
rtl/interleaved_minmax_normalizer.sv
test/testbench.sv
